### hdl/txc_pkg.sv
// ----------------------------------------------------------------------------
// txc_pkg
// Shared types, codes and the control store of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package txc_pkg;

  localparam int COLS_DEFAULT = 80;
  localparam int ROWS_DEFAULT = 25;
  localparam int TAB_DEFAULT  = 4;

  localparam logic [7:0] BLANK  = 8'h20;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam int STW = 4;
  typedef logic [STW-1:0] step_t;

  localparam step_t S_INIT      = 4'd0;
  localparam step_t S_IDLE      = 4'd1;
  localparam step_t S_WRITE     = 4'd2;
  localparam step_t S_CHECK     = 4'd3;
  localparam step_t S_NL        = 4'd4;
  localparam step_t S_CR        = 4'd5;
  localparam step_t S_BS        = 4'd6;
  localparam step_t S_CLR       = 4'd7;
  localparam step_t S_RD        = 4'd8;
  localparam step_t S_SCR_START = 4'd9;
  localparam step_t S_SCR_LOOP  = 4'd10;
  localparam step_t S_SCR_DRAIN = 4'd11;
  localparam step_t S_DONE      = 4'd12;

  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_INIT      = 4'd1,
    ACT_WRITE     = 4'd2,
    ACT_NL        = 4'd3,
    ACT_CR        = 4'd4,
    ACT_BS        = 4'd5,
    ACT_CLR       = 4'd6,
    ACT_SCR_START = 4'd7,
    ACT_SCROLL    = 4'd8,
    ACT_RESULT    = 4'd9
  } act_t;

  typedef enum logic [2:0] {
    COND_NEVER        = 3'd0,
    COND_NO_CMD       = 3'd1,
    COND_AT_END       = 3'd2,
    COND_CNT_NZ       = 3'd3,
    COND_LAST_ROW     = 3'd4,
    COND_PTR_NOT_LAST = 3'd5,
    COND_OUT_BUSY     = 3'd6
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t jmp;
    step_t nxt;
    logic  disp;
  } cw_t;

  function automatic cw_t ucode(step_t s);
    cw_t cw;
    cw = '{act: ACT_NONE, cond: COND_NEVER, jmp: S_IDLE, nxt: S_IDLE, disp: 1'b0};
    unique case (s)
      S_INIT:      cw = '{act: ACT_INIT, cond: COND_PTR_NOT_LAST, jmp: S_INIT,
                          nxt: S_IDLE, disp: 1'b0};
      S_IDLE:      cw = '{act: ACT_NONE, cond: COND_NO_CMD, jmp: S_IDLE,
                          nxt: S_IDLE, disp: 1'b1};
      S_WRITE:     cw = '{act: ACT_WRITE, cond: COND_AT_END, jmp: S_SCR_START,
                          nxt: S_CHECK, disp: 1'b0};
      S_CHECK:     cw = '{act: ACT_NONE, cond: COND_CNT_NZ, jmp: S_WRITE,
                          nxt: S_DONE, disp: 1'b0};
      S_NL:        cw = '{act: ACT_NL, cond: COND_LAST_ROW, jmp: S_SCR_START,
                          nxt: S_DONE, disp: 1'b0};
      S_CR:        cw = '{act: ACT_CR, cond: COND_NEVER, jmp: S_DONE,
                          nxt: S_DONE, disp: 1'b0};
      S_BS:        cw = '{act: ACT_BS, cond: COND_NEVER, jmp: S_DONE,
                          nxt: S_DONE, disp: 1'b0};
      S_CLR:       cw = '{act: ACT_CLR, cond: COND_PTR_NOT_LAST, jmp: S_CLR,
                          nxt: S_DONE, disp: 1'b0};
      S_RD:        cw = '{act: ACT_NONE, cond: COND_NEVER, jmp: S_DONE,
                          nxt: S_DONE, disp: 1'b0};
      S_SCR_START: cw = '{act: ACT_SCR_START, cond: COND_NEVER, jmp: S_SCR_LOOP,
                          nxt: S_SCR_LOOP, disp: 1'b0};
      S_SCR_LOOP:  cw = '{act: ACT_SCROLL, cond: COND_PTR_NOT_LAST, jmp: S_SCR_LOOP,
                          nxt: S_SCR_DRAIN, disp: 1'b0};
      S_SCR_DRAIN: cw = '{act: ACT_NONE, cond: COND_NEVER, jmp: S_CHECK,
                          nxt: S_CHECK, disp: 1'b0};
      S_DONE:      cw = '{act: ACT_RESULT, cond: COND_OUT_BUSY, jmp: S_DONE,
                          nxt: S_IDLE, disp: 1'b0};
      default:     cw = '{act: ACT_NONE, cond: COND_NEVER, jmp: S_IDLE,
                          nxt: S_IDLE, disp: 1'b0};
    endcase
    return cw;
  endfunction

  function automatic step_t entry(logic [1:0] func, logic [7:0] ch);
    step_t s;
    s = S_DONE;
    unique case (func)
      FUNC_PUT: begin
        if (ch == CH_LF) s = S_NL;
        else if (ch == CH_CR) s = S_CR;
        else if (ch == CH_BS) s = S_BS;
        else s = S_WRITE;
      end
      FUNC_CLEAR: s = S_CLR;
      FUNC_READ:  s = S_RD;
      default:    s = S_DONE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell console: screen memory, cursor and a microcoded sequencer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the COLS*ROWS screen memory to zero, one cell a
// cycle, and takes no command until done. Every command returns one response.
// A printable character runs the write, check and done steps, a tab repeats
// write and check for each of its TAB_SPACES blanks; newline, carriage return,
// backspace and read run their own step, then done. Clear sweeps the whole
// screen through the write port of the screen memory, one cell a cycle. A
// scroll inside a put copies each row up one row and blanks the bottom row. A
// stalled response holds the block in its done step.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int COLS       = txc_pkg::COLS_DEFAULT,
  parameter int ROWS       = txc_pkg::ROWS_DEFAULT,
  parameter int TAB_SPACES = txc_pkg::TAB_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  char_code,
  input  wire logic [3:0]  ink_color,
  input  wire logic [3:0]  paper_color,
  input  wire logic [10:0] cell_addr,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [10:0]      cursor_pos,
  output logic [7:0]       read_char,
  output logic [7:0]       read_style,
  output logic             scrolled
);

  localparam int EXTENT = COLS * ROWS;
  localparam int AW     = $clog2(EXTENT);
  localparam int CW     = $clog2(COLS);
  localparam int TW     = $clog2(TAB_SPACES + 1);

  txc_pkg::step_t step;
  txc_pkg::step_t step_next;
  txc_pkg::cw_t   cw;
  logic           cond_true;
  logic           accept;
  logic           out_busy;
  logic           at_end;
  logic           last_row;
  logic           ptr_last;

  logic [AW-1:0]  cursor;
  logic [CW-1:0]  col;
  logic [AW-1:0]  ptr;
  logic [TW-1:0]  cnt;
  logic [7:0]     wchar;
  logic [7:0]     style;
  logic [AW-1:0]  rd_idx;
  logic           rd_ok;
  logic           scr;
  logic           sw_en;
  logic [AW-1:0]  sw_addr;
  logic           sw_bot;
  logic [AW-1:0]  scr_src;

  logic [15:0]    mem [EXTENT];
  logic [15:0]    mem_q;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  logic [15:0]    mem_wd;
  logic [AW-1:0]  mem_ra;

  assign cw        = txc_pkg::ucode(step);
  assign cmd_stall = (step != txc_pkg::S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_busy  = rsp_valid && rsp_stall;
  assign at_end    = (cursor == AW'(EXTENT - 1));
  assign last_row  = (cursor >= AW'(EXTENT - COLS));
  assign ptr_last  = (ptr == AW'(EXTENT - 1));
  assign scr_src   = (ptr < AW'(EXTENT - COLS)) ? ptr + AW'(COLS) : ptr;

  always_comb begin
    unique case (cw.cond)
      txc_pkg::COND_NEVER:        cond_true = 1'b0;
      txc_pkg::COND_NO_CMD:       cond_true = !cmd_valid;
      txc_pkg::COND_AT_END:       cond_true = at_end;
      txc_pkg::COND_CNT_NZ:       cond_true = (cnt != '0);
      txc_pkg::COND_LAST_ROW:     cond_true = last_row;
      txc_pkg::COND_PTR_NOT_LAST: cond_true = !ptr_last;
      txc_pkg::COND_OUT_BUSY:     cond_true = out_busy;
      default:                    cond_true = 1'b0;
    endcase
  end

  always_comb begin
    priority if (cond_true) begin
      step_next = cw.jmp;
    end else if (cw.disp) begin
      step_next = txc_pkg::entry(func, char_code);
    end else begin
      step_next = cw.nxt;
    end
  end

  // screen memory write port; pending scroll copy has priority
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cursor;
    mem_wd = {style, wchar};
    if (sw_en) begin
      mem_we = 1'b1;
      mem_wa = sw_addr;
      mem_wd = sw_bot ? {mem_q[15:8], txc_pkg::BLANK} : mem_q;
    end else begin
      unique case (cw.act)
        txc_pkg::ACT_INIT: begin
          mem_we = 1'b1;
          mem_wa = ptr;
          mem_wd = '0;
        end
        txc_pkg::ACT_CLR: begin
          mem_we = 1'b1;
          mem_wa = ptr;
          mem_wd = {style, txc_pkg::BLANK};
        end
        txc_pkg::ACT_WRITE: begin
          mem_we = 1'b1;
        end
        txc_pkg::ACT_BS: begin
          mem_we = (cursor != '0);
          mem_wa = cursor - AW'(1);
          mem_wd = {style, txc_pkg::BLANK};
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  assign mem_ra = (cw.act == txc_pkg::ACT_SCROLL) ? scr_src : rd_idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= txc_pkg::S_INIT;
      cursor    <= '0;
      col       <= '0;
      ptr       <= '0;
      cnt       <= '0;
      sw_en     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      step  <= step_next;
      sw_en <= (cw.act == txc_pkg::ACT_SCROLL);
      if (rsp_valid && !rsp_stall && cw.act != txc_pkg::ACT_RESULT) begin
        rsp_valid <= 1'b0;
      end
      if (accept) begin
        ptr <= '0;
        if (func == txc_pkg::FUNC_PUT && char_code != txc_pkg::CH_LF &&
            char_code != txc_pkg::CH_CR && char_code != txc_pkg::CH_BS) begin
          cnt <= (char_code == txc_pkg::CH_TAB) ? TW'(TAB_SPACES) : TW'(1);
        end else begin
          cnt <= '0;
        end
      end
      unique case (cw.act)
        txc_pkg::ACT_INIT, txc_pkg::ACT_CLR, txc_pkg::ACT_SCROLL: begin
          ptr <= ptr + AW'(1);
        end
        txc_pkg::ACT_WRITE: begin
          cnt <= cnt - TW'(1);
          if (!at_end) begin
            cursor <= cursor + AW'(1);
          end
          col <= (col == CW'(COLS - 1)) ? '0 : col + CW'(1);
        end
        txc_pkg::ACT_NL: begin
          if (!last_row) begin
            cursor <= cursor - AW'(col) + AW'(COLS);
          end
          col <= '0;
        end
        txc_pkg::ACT_CR: begin
          cursor <= cursor - AW'(col);
          col    <= '0;
        end
        txc_pkg::ACT_BS: begin
          if (cursor != '0) begin
            cursor <= cursor - AW'(1);
            col    <= (col == '0) ? CW'(COLS - 1) : col - CW'(1);
          end
        end
        txc_pkg::ACT_SCR_START: begin
          cursor <= AW'(EXTENT - COLS);
          col    <= '0;
          ptr    <= '0;
        end
        txc_pkg::ACT_RESULT: begin
          if (!out_busy) begin
            rsp_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      style  <= {paper_color, ink_color};
      wchar  <= (char_code == txc_pkg::CH_TAB) ? txc_pkg::BLANK : char_code;
      rd_idx <= AW'(cell_addr);
      rd_ok  <= (func == txc_pkg::FUNC_READ) && (32'(cell_addr) < EXTENT);
      scr    <= 1'b0;
    end else if (cw.act == txc_pkg::ACT_SCR_START) begin
      scr <= 1'b1;
    end
    if (cw.act == txc_pkg::ACT_SCROLL) begin
      sw_addr <= ptr;
      sw_bot  <= (ptr >= AW'(EXTENT - COLS));
    end
    if (cw.act == txc_pkg::ACT_RESULT && !out_busy) begin
      cursor_pos <= 11'(cursor);
      read_char  <= rd_ok ? mem_q[7:0] : 8'd0;
      read_style <= rd_ok ? mem_q[15:8] : 8'd0;
      scrolled   <= scr;
    end
  end

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    32'(cursor) < EXTENT)
    else $error("cursor off screen");

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    32'(col) < COLS)
    else $error("column out of range");

  a_copy_port_free: assert property (@(posedge clk) disable iff (rst)
    sw_en |-> (cw.act == txc_pkg::ACT_SCROLL || cw.act == txc_pkg::ACT_NONE))
    else $error("scroll copy collides with another write");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(step) == txc_pkg::S_DONE)
    else $error("response raised outside done step");

  a_cmd_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> step != txc_pkg::S_IDLE)
    else $error("transfer did not start a command");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (step == txc_pkg::S_DONE && !out_busy) |=> rsp_valid)
    else $error("done step did not post a response");

endmodule

`default_nettype wire
